[rtl/fnaf_pkg.sv]
`timescale 1ns / 1ps
package fnaf_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 2'd1;

  // Register values after reset
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // Divide by three as multiply by ceil(2^19 / 3), exact for sums below 2^19
  localparam logic [17:0] DIV3_MUL   = 18'd174763;
  localparam int          DIV3_SHIFT = 19;

  // Result slots an item can produce, in output order
  typedef enum logic [1:0] {
    SLOT_ABOVE,   // pixel one row up, same column
    SLOT_LEFT,    // last row, pixel one column left
    SLOT_LAST     // last row, final pixel of the frame
  } fnaf_slot_t;

  // Position facts of one input word, worked out at accept time
  typedef struct packed {
    logic has_above;
    logic has_left;
    logic has_last;
    logic col_ge1;
    logic col_ge2;
    logic row_ge1;
    logic row_ge2;
    logic has_right;
  } fnaf_flags_t;

  // Line store read ports that must take the write in flight instead
  typedef struct packed {
    logic a0;
    logic a1;
    logic bm;
    logic b0;
  } fnaf_hit_t;

endpackage

[rtl/four_neighbor_average_filter_core.sv]
`timescale 1ns / 1ps
// Channel | Dir | Handshake            | Payload
// s_      | in  | s_tvalid / s_tready  | s_tdata: pixel_value
// m_      | out | m_tvalid / m_tready  | m_tdata: out_row, out_col, filtered_value;
//         |     |                      | m_tlast: last_of_run; m_tuser: frame_done
// cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One pixel is taken per clock while s_tready is high. A pixel passes an input stage (line
// store read), a slot stage and the output register. The slot stage hands one result per
// cycle to the output register unless m_tready holds it, so on the last row (up to 3 results
// per pixel) the input rate follows the output at 1 result/clock.
// Reset is synchronous; line stores are not cleared and need no sweep after reset.
// A low m_tready holds the output register; with the slot and input stages full,
// s_tready drops in the same cycle.
module four_neighbor_average_filter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,   // [15:0] pixel_value
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [47:0]                       m_tdata,   // [15:0] out_row, [25:16] out_col,
                                                       // [41:26] filtered_value, [47:42] zero
  output logic                              m_tlast,   // last_of_run
  output logic                              m_tuser,   // frame_done
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fnaf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]                       cfg_data
);
  import fnaf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = PIXEL_BITS;
  localparam int SW = PIXEL_BITS + 2;

  // Configuration
  logic [10:0] cfg_width;
  logic [15:0] cfg_height;
  logic        cfg_acc;
  logic        cfg_restart;

  // Position and pixel history
  logic [15:0]    row_cnt;
  logic [AW-1:0]  col_cnt;
  logic [PW-1:0]  prior_px;
  logic [PW-1:0]  prior2_px;

  // Accept-time decode
  logic           in_acc;
  logic [WW-1:0]  eff_w;
  logic [AW-1:0]  eff_wm1;
  logic [15:0]    eff_h;
  logic [15:0]    r0;
  logic [AW-1:0]  c0;
  logic           last_row;
  logic           end_col;
  fnaf_flags_t    flags0;
  logic [15:0]    row_cnt_next;
  logic [AW-1:0]  col_cnt_next;
  logic [PW-1:0]  px0;
  fnaf_hit_t      hit0;

  // Input stage
  logic           s1_valid;
  logic           s1_new;
  logic [PW-1:0]  s1_px;
  logic [PW-1:0]  s1_p1;
  logic [PW-1:0]  s1_p2;
  logic [15:0]    s1_row;
  logic [AW-1:0]  s1_col;
  fnaf_flags_t    s1_flags;
  fnaf_hit_t      s1_hit;
  logic [PW-1:0]  byp_a;
  logic [PW-1:0]  byp_b;
  logic [PW-1:0]  ram_a_rd0;
  logic [PW-1:0]  ram_a_rd1;
  logic [PW-1:0]  ram_b_rd0;
  logic [PW-1:0]  ram_b_rd1;
  logic [PW-1:0]  a0_eff;
  logic [PW-1:0]  a1_eff;
  logic [PW-1:0]  bm_eff;
  logic [PW-1:0]  b0_eff;
  logic [SW-1:0]  sum0;
  logic [SW-1:0]  sum1;
  logic [SW-1:0]  sum2;
  logic [2:0]     cnt0;
  logic [2:0]     cnt1;
  logic [2:0]     cnt2;
  logic           s1_nores;
  logic           s1_adv;

  // Slot stage
  logic [2:0]     s2_mask;
  logic [15:0]    s2_row [3];
  logic [AW-1:0]  s2_col [3];
  logic [SW-1:0]  s2_sum [3];
  logic [2:0]     s2_cnt [3];
  logic           s2_valid;
  logic           s2_single;
  logic           s2_free;
  logic           s2_load;
  fnaf_slot_t     sel;
  logic [SW-1:0]  sel_sum;
  logic [2:0]     sel_cnt;
  logic [SW+17:0] prod;
  logic [PW-1:0]  quot;
  logic           out_load;

  assign cfg_ready   = 1'b1;
  assign cfg_acc     = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_acc && (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RESET;
      cfg_height <= HEIGHT_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  cfg_width  <= cfg_data[10:0];
        CFG_IDX_HEIGHT: cfg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp frame size
  always_comb begin
    if (cfg_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_width);
    end
    eff_wm1 = AW'(eff_w - WW'(1));
    eff_h   = (cfg_height == '0) ? 16'd1 : cfg_height;
  end

  assign in_acc = s_tvalid && s_tready;
  assign px0    = s_tdata[PW-1:0];

  // Decode the position of the incoming word
  always_comb begin
    if (row_cnt >= eff_h || WW'(col_cnt) >= eff_w) begin
      r0 = '0;
      c0 = '0;
    end else begin
      r0 = row_cnt;
      c0 = col_cnt;
    end
    last_row = (r0 == eff_h - 16'd1);
    end_col  = (c0 == eff_wm1);

    flags0.row_ge1   = (r0 != '0);
    flags0.row_ge2   = (r0 > 16'd1);
    flags0.col_ge1   = (c0 != '0);
    flags0.col_ge2   = (c0 > AW'(1));
    flags0.has_right = !end_col;
    flags0.has_above = flags0.row_ge1;
    flags0.has_left  = last_row && flags0.col_ge1;
    flags0.has_last  = last_row && end_col;

    if (flags0.has_last) begin
      row_cnt_next = '0;
      col_cnt_next = '0;
    end else if (end_col) begin
      row_cnt_next = r0 + 16'd1;
      col_cnt_next = '0;
    end else begin
      row_cnt_next = r0;
      col_cnt_next = c0 + AW'(1);
    end
  end

  // Advance position and pixel history
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      col_cnt   <= '0;
      prior_px  <= '0;
      prior2_px <= '0;
    end else begin
      if (cfg_restart) begin
        row_cnt <= '0;
        col_cnt <= '0;
      end else if (in_acc) begin
        row_cnt <= row_cnt_next;
        col_cnt <= col_cnt_next;
      end
      if (in_acc) begin
        prior_px  <= px0;
        prior2_px <= prior_px;
      end
    end
  end

  // Line stores: a holds the row above, b the row before that
  fnaf_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk    (clk),
    .we     (s1_new),
    .waddr  (s1_col),
    .wdata  (s1_px),
    .re     (in_acc),
    .raddr0 (c0),
    .raddr1 (c0 + AW'(1)),
    .rdata0 (ram_a_rd0),
    .rdata1 (ram_a_rd1)
  );

  fnaf_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk    (clk),
    .we     (s1_new),
    .waddr  (s1_col),
    .wdata  (a0_eff),
    .re     (in_acc),
    .raddr0 (c0 - AW'(1)),
    .raddr1 (c0),
    .rdata0 (ram_b_rd0),
    .rdata1 (ram_b_rd1)
  );

  // Flag reads that collide with the store write of the word ahead
  always_comb begin
    hit0.a0 = s1_new && (c0 == s1_col);
    hit0.a1 = s1_new && ((c0 + AW'(1)) == s1_col);
    hit0.bm = s1_new && ((c0 - AW'(1)) == s1_col);
    hit0.b0 = s1_new && (c0 == s1_col);
  end

  // Input stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_new   <= 1'b0;
    end else begin
      s1_new <= in_acc;
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px    <= px0;
      s1_p1    <= prior_px;
      s1_p2    <= prior2_px;
      s1_row   <= r0;
      s1_col   <= c0;
      s1_flags <= flags0;
      s1_hit   <= hit0;
      byp_a    <= s1_px;
      byp_b    <= a0_eff;
    end
  end

  // Neighbor values with forwarding
  assign a0_eff = s1_hit.a0 ? byp_a : ram_a_rd0;
  assign a1_eff = s1_hit.a1 ? byp_a : ram_a_rd1;
  assign bm_eff = s1_hit.bm ? byp_b : ram_b_rd0;
  assign b0_eff = s1_hit.b0 ? byp_b : ram_b_rd1;

  // Neighbor sums and counts for the three slots
  always_comb begin
    sum0 = SW'(s1_px)
         + (s1_flags.row_ge2   ? SW'(b0_eff) : '0)
         + (s1_flags.col_ge1   ? SW'(bm_eff) : '0)
         + (s1_flags.has_right ? SW'(a1_eff) : '0);
    cnt0 = 3'd1 + {2'b00, s1_flags.row_ge2} + {2'b00, s1_flags.col_ge1}
         + {2'b00, s1_flags.has_right};
    sum1 = SW'(s1_px)
         + (s1_flags.col_ge2 ? SW'(s1_p2)  : '0)
         + (s1_flags.row_ge1 ? SW'(bm_eff) : '0);
    cnt1 = 3'd1 + {2'b00, s1_flags.col_ge2} + {2'b00, s1_flags.row_ge1};
    sum2 = (s1_flags.col_ge1 ? SW'(s1_p1)  : '0)
         + (s1_flags.row_ge1 ? SW'(a0_eff) : '0);
    cnt2 = {2'b00, s1_flags.col_ge1} + {2'b00, s1_flags.row_ge1};
  end

  // Handshake chain: output register, slot stage, input stage
  assign s2_valid  = (s2_mask != '0);
  assign out_load  = s2_valid && (!m_tvalid || m_tready);
  assign s2_single = ((s2_mask & (s2_mask - 3'd1)) == '0);
  assign s2_free   = !s2_valid || (out_load && s2_single);
  assign s1_nores  = !(s1_flags.has_above || s1_flags.has_left || s1_flags.has_last);
  assign s1_adv    = s1_valid && (s1_nores || s2_free);
  assign s2_load   = s1_adv && !s1_nores;
  assign s_tready  = !s1_valid || s1_adv;

  // Pick the lowest pending slot
  always_comb begin
    if (s2_mask[SLOT_ABOVE]) begin
      sel = SLOT_ABOVE;
    end else if (s2_mask[SLOT_LEFT]) begin
      sel = SLOT_LEFT;
    end else begin
      sel = SLOT_LAST;
    end
  end

  // Slot stage mask
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_mask <= '0;
    end else if (s2_load) begin
      s2_mask <= {s1_flags.has_last, s1_flags.has_left, s1_flags.has_above};
    end else if (out_load) begin
      s2_mask <= s2_mask & ~(3'b001 << sel);
    end
  end

  // Slot stage payload
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_row[SLOT_ABOVE] <= s1_row - 16'd1;
      s2_col[SLOT_ABOVE] <= s1_col;
      s2_sum[SLOT_ABOVE] <= sum0;
      s2_cnt[SLOT_ABOVE] <= cnt0;
      s2_row[SLOT_LEFT]  <= s1_row;
      s2_col[SLOT_LEFT]  <= s1_col - AW'(1);
      s2_sum[SLOT_LEFT]  <= sum1;
      s2_cnt[SLOT_LEFT]  <= cnt1;
      s2_row[SLOT_LAST]  <= s1_row;
      s2_col[SLOT_LAST]  <= s1_col;
      s2_sum[SLOT_LAST]  <= sum2;
      s2_cnt[SLOT_LAST]  <= cnt2;
    end
  end

  // Mean of the selected slot
  assign sel_sum = s2_sum[sel];
  assign sel_cnt = s2_cnt[sel];
  assign prod    = (SW+18)'(sel_sum) * (SW+18)'(DIV3_MUL);

  always_comb begin
    case (sel_cnt)
      3'd1:    quot = PW'(sel_sum);
      3'd2:    quot = PW'(sel_sum >> 1);
      3'd3:    quot = PW'(prod >> DIV3_SHIFT);
      3'd4:    quot = PW'(sel_sum >> 2);
      default: quot = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b000000, 16'(quot), 10'(s2_col[sel]), s2_row[sel]};
      m_tlast <= s2_single;
      m_tuser <= (sel == SLOT_LAST);
    end
  end

  // The frame's final result closes its run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame_done without last_of_run");

  // A stalled result word holds until it is taken
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result word changed while stalled");

  // The final pixel of a frame returns the position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc && flags0.has_last |=> row_cnt == '0 && col_cnt == '0)
    else $error("position did not wrap after the final pixel");

endmodule

[rtl/fnaf_ram.sv]
`timescale 1ns / 1ps
module fnaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered reads, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

[sim/four_neighbor_average_filter_checker.sv]
`timescale 1ns / 1ps
module four_neighbor_average_filter_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [15:0]                       s_tdata,   // [15:0] pixel_value
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [47:0]                       m_tdata,   // [15:0] out_row, [25:16] out_col,
                                                       // [41:26] filtered_value
  input  logic                              m_tlast,   // last_of_run
  input  logic                              m_tuser,   // frame_done
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [fnaf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]                       cfg_data,
  output int                                fail_count,
  output int                                results_owed
);
  import fnaf_pkg::*;

  localparam int LINE_DEPTH   = 1024;
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic [15:0] row;
    logic [9:0]  col;
    logic [15:0] value;
    logic        last;
    logic        done;
  } filt_result_t;

  // Shadow of the block: registers, line stores, position and row history
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic [15:0] prev_line [LINE_DEPTH];
  logic [15:0] prev2_line [LINE_DEPTH];
  int          row_pos;
  int          col_pos;
  logic [15:0] left_px;
  logic [15:0] left2_px;

  filt_result_t filtered_queue[$];

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  function automatic filt_result_t make_result(input int r, input int c, input int sum,
                                               input int cnt, input logic done);
    filt_result_t res;
    res.row   = r[15:0];
    res.col   = c[9:0];
    res.value = (cnt == 0) ? 16'd0 : 16'(sum / cnt);
    res.last  = 1'b0;
    res.done  = done;
    return res;
  endfunction

  // Work out the results one pixel word causes and advance the shadow state
  task automatic filter_pixel(input logic [15:0] px);
    int           w;
    int           h;
    int           r;
    int           c;
    int           sum;
    int           cnt;
    int           k;
    logic         last_row;
    logic         final_px;
    filt_result_t res [3];
    w = (width_reg == 0) ? 1 : int'(width_reg);
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = (height_reg == 0) ? 1 : int'(height_reg);
    r = row_pos;
    c = col_pos;
    k = 0;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    last_row = (r + 1 == h);
    final_px = last_row && (c + 1 == w);

    // Pixel one row up, now that its lower neighbor is here
    if (r >= 1) begin
      sum = px;
      cnt = 1;
      if (c >= 1) begin
        sum += prev2_line[c-1];
        cnt++;
      end
      if (r >= 2) begin
        sum += prev2_line[c];
        cnt++;
      end
      if (c + 1 < w) begin
        sum += prev_line[c+1];
        cnt++;
      end
      res[k] = make_result(r - 1, c, sum, cnt, 1'b0);
      k++;
    end
    // Last row: pixel to the left is complete
    if (last_row && c >= 1) begin
      sum = px;
      cnt = 1;
      if (c >= 2) begin
        sum += left2_px;
        cnt++;
      end
      if (r >= 1) begin
        sum += prev2_line[c-1];
        cnt++;
      end
      res[k] = make_result(r, c - 1, sum, cnt, 1'b0);
      k++;
    end
    // Final pixel of the frame
    if (final_px) begin
      sum = 0;
      cnt = 0;
      if (c >= 1) begin
        sum += left_px;
        cnt++;
      end
      if (r >= 1) begin
        sum += prev_line[c];
        cnt++;
      end
      res[k] = make_result(r, c, sum, cnt, 1'b1);
      k++;
    end

    prev2_line[c] = prev_line[c];
    prev_line[c]  = px;
    left2_px      = left_px;
    left_px       = px;

    if (final_px) begin
      r = 0;
      c = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
    end
    row_pos = r;
    col_pos = c;

    for (int i = 0; i < k; i++) begin
      res[i].last = (i == k - 1);
      filtered_queue.push_back(res[i]);
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
    end
  endtask

  // Track config writes, predict on every accepted pixel, compare every result word
  always @(posedge clk) begin
    filt_result_t exp_res;
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      row_pos    = 0;
      col_pos    = 0;
      left_px    = '0;
      left2_px   = '0;
      filtered_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_WIDTH) begin
          width_reg = cfg_data[10:0];
          row_pos   = 0;
          col_pos   = 0;
        end else if (cfg_index == CFG_IDX_HEIGHT) begin
          height_reg = cfg_data;
          row_pos    = 0;
          col_pos    = 0;
        end
      end
      if (s_tvalid && s_tready)
        filter_pixel(s_tdata);
      if (m_tvalid && m_tready) begin
        if (filtered_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $error("result word with nothing pending: row %0d col %0d value %0d",
                   m_tdata[15:0], m_tdata[25:16], m_tdata[41:26]);
        end else begin
          exp_res = filtered_queue.pop_front();
          check_field("out_row", exp_res.row, m_tdata[15:0]);
          check_field("out_col", exp_res.col, m_tdata[25:16]);
          check_field("filtered_value", exp_res.value, m_tdata[41:26]);
          check_field("last_of_run", exp_res.last, m_tlast);
          check_field("frame_done", exp_res.done, m_tuser);
        end
      end
    end
    results_owed = filtered_queue.size();
  end

endmodule

[sim/four_neighbor_average_filter_core_tb.sv]
`timescale 1ns / 1ps
module four_neighbor_average_filter_core_tb;
  import fnaf_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 35;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE3 = 2'd3;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [15:0]             s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b1;
  logic [47:0]             m_tdata;
  logic                    m_tlast;
  logic                    m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [15:0]             cfg_data  = '0;

  int   fail_count;
  int   results_owed;
  int   cycle_count    = 0;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  logic hold_pending   = 1'b0;
  logic hold_taken     = 1'b0;
  int   src_pcts [4]   = '{0, 52, 0, 32};
  int   sink_pcts [4]  = '{0, 0, 52, 32};

  four_neighbor_average_filter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  four_neighbor_average_filter_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[four_neighbor_average_filter_core] ERROR");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending && !hold_taken) begin
        hold_taken = 1'b1;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Bias toward the extremes so sums reach their largest values and every bit toggles
  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one pixel word; valid stays high into the next call unless a gap is drawn
  task automatic send_pixel(input logic [15:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted word, then let the pipeline settle
  task automatic finish_results();
    s_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame(input logic [15:0] width_val, input logic [15:0] height_val);
    write_reg(CFG_IDX_WIDTH, width_val);
    write_reg(CFG_IDX_HEIGHT, height_val);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: the top row gives no results yet
    for (int i = 0; i < 5; i++) send_pixel(rand_pixel());
    finish_results();

    // 1x1 frames, including zero width and height taken as one
    set_frame(16'd1, 16'd1);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    finish_results();
    set_frame(16'hF800, 16'd0);
    send_pixel(16'h1234);
    finish_results();

    // Writes to unused indexes leave geometry and position alone
    write_reg(CFG_IDX_SPARE2, 16'hFFFF);
    write_reg(CFG_IDX_SPARE3, 16'h0000);
    send_pixel(16'hFFFF);
    finish_results();

    // Small frames with saturated and empty pixels
    set_frame(16'd2, 16'd2);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    finish_results();
    set_frame(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) send_pixel((i % 2 == 0) ? 16'hFFFF : 16'h0000);
    finish_results();

    // Single-row frame: everything comes from the last-row path
    set_frame(16'd4, 16'd1);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'h0001);
    send_pixel(16'h8000);
    finish_results();

    // Random pixels under each idling mode; 4x8 geometry with the long hold-off first, then random
    for (int m = 0; m < 4; m++) begin
      src_idle_pct   = src_pcts[m];
      sink_stall_pct = sink_pcts[m];
      if (m == 0) begin
        set_frame(16'd4, 16'd8);
        hold_pending = 1'b1;
      end else begin
        set_frame(16'($urandom_range(1, 10)), 16'($urandom_range(1, 6)));
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) send_pixel(rand_pixel());
      finish_results();
    end

    // Widest row: width bits all set, clamped to the line store depth, single row
    src_idle_pct   = 32;
    sink_stall_pct = 32;
    set_frame(16'hFFFF, 16'd1);
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
    finish_results();

    // Tallest frame, one pixel wide
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_frame(16'd1, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
    finish_results();

    if (fail_count == 0 && results_owed == 0)
      $display("[four_neighbor_average_filter_core] OK");
    else
      $display("[four_neighbor_average_filter_core] ERROR");
    $finish;
  end

endmodule
